/* rtl/idck_pkg.sv */
// Package for the ID number MOD 11-2 checker: request/result types, state type,
// error codes and the constant tables as functions.
// No dependencies.
package idck_pkg;

  localparam int unsigned ID_LEN       = 18;
  localparam int unsigned POS_SAT      = 19;
  localparam logic [7:0]  CHAR_ZERO    = 8'h30;
  localparam logic [7:0]  CHAR_NINE    = 8'h39;
  localparam logic [7:0]  CHAR_X_UPPER = 8'h58;
  localparam logic [7:0]  CHAR_X_LOWER = 8'h78;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_LENGTH     = 3'd1,
    ERR_NON_DIGIT  = 3'd2,
    ERR_CHECK_FORM = 3'd3,
    ERR_CHECKSUM   = 3'd4,
    ERR_DATE       = 3'd5
  } err_code_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } req_t;

  typedef struct packed {
    logic        valid_res;
    err_code_t   error_code;
    logic [13:0] birth_year;
    logic [3:0]  birth_month;
    logic [4:0]  birth_day;
    logic        is_female;
    logic [3:0]  animal_index;
    logic [3:0]  star_index;
  } res_t;

  typedef struct packed {
    logic [4:0]  char_position;
    logic [3:0]  weighted_sum_mod;
    logic        saw_non_digit;
    logic [13:0] year_digits;
    logic [6:0]  month_digits;
    logic [6:0]  day_digits;
    logic        sex_digit_odd;
  } acc_state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [3:0] weight_of(input logic [4:0] pos);
    logic [3:0] w;
    case (pos)
      5'd0:    w = 4'd7;
      5'd1:    w = 4'd9;
      5'd2:    w = 4'd10;
      5'd3:    w = 4'd5;
      5'd4:    w = 4'd8;
      5'd5:    w = 4'd4;
      5'd6:    w = 4'd2;
      5'd7:    w = 4'd1;
      5'd8:    w = 4'd6;
      5'd9:    w = 4'd3;
      5'd10:   w = 4'd7;
      5'd11:   w = 4'd9;
      5'd12:   w = 4'd10;
      5'd13:   w = 4'd5;
      5'd14:   w = 4'd8;
      5'd15:   w = 4'd4;
      5'd16:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] check_char(input logic [3:0] sum);
    logic [7:0] c;
    case (sum)
      4'd0:    c = 8'h31;
      4'd1:    c = 8'h30;
      4'd2:    c = CHAR_X_UPPER;
      4'd3:    c = 8'h39;
      4'd4:    c = 8'h38;
      4'd5:    c = 8'h37;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h35;
      4'd8:    c = 8'h34;
      4'd9:    c = 8'h33;
      4'd10:   c = 8'h32;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] star_cut(input logic [3:0] m);
    logic [4:0] cut;
    case (m)
      4'd1:    cut = 5'd21;
      4'd2:    cut = 5'd20;
      4'd3:    cut = 5'd21;
      4'd4:    cut = 5'd21;
      4'd5:    cut = 5'd22;
      4'd6:    cut = 5'd22;
      4'd7:    cut = 5'd23;
      4'd8:    cut = 5'd24;
      4'd9:    cut = 5'd24;
      4'd10:   cut = 5'd24;
      4'd11:   cut = 5'd23;
      4'd12:   cut = 5'd22;
      default: cut = 5'd0;
    endcase
    return cut;
  endfunction

  // v <= 100; reciprocal 187/2048
  function automatic logic [3:0] mod11_small(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = 15'(v) * 15'd187;
    q = p[14:11];
    r = v - 7'(q) * 7'd11;
    return r[3:0];
  endfunction

  // v < 16392; reciprocal 10923/2^17
  function automatic logic [3:0] mod12(input logic [14:0] v);
    logic [27:0] p;
    logic [10:0] q;
    logic [14:0] r;
    p = 28'(v) * 28'd10923;
    q = p[27:17];
    r = v - 15'(q) * 15'd12;
    return r[3:0];
  endfunction

endpackage

/* rtl/idck_acc.sv */
// Running state of the number being received: position, weighted sum mod 11,
// non-digit flag and date/sex digits. Depends on idck_pkg.
module idck_acc (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  idck_pkg::req_t    req,
  output idck_pkg::acc_state_t st
);
  import idck_pkg::*;

  acc_state_t st_next;
  logic [3:0] d;
  logic [7:0] prod;
  logic [6:0] sum_wide;

  assign d        = req.char_code[3:0];
  assign prod     = 8'(d) * 8'(weight_of(st.char_position));
  assign sum_wide = 7'(st.weighted_sum_mod) + prod[6:0];

  always_comb begin
    st_next = st;
    if (req.is_last) begin
      st_next = '0;
    end else begin
      if (st.char_position < 5'(ID_LEN - 1)) begin
        if (!is_digit(req.char_code)) begin
          st_next.saw_non_digit = 1'b1;
        end else begin
          st_next.weighted_sum_mod = mod11_small(sum_wide);
          if (st.char_position inside {[5'd6:5'd9]}) begin
            st_next.year_digits = st.year_digits * 14'd10 + 14'(d);
          end else if (st.char_position inside {[5'd10:5'd11]}) begin
            st_next.month_digits = st.month_digits * 7'd10 + 7'(d);
          end else if (st.char_position inside {[5'd12:5'd13]}) begin
            st_next.day_digits = st.day_digits * 7'd10 + 7'(d);
          end else if (st.char_position == 5'd16) begin
            st_next.sex_digit_odd = d[0];
          end
        end
      end
      if (st.char_position < 5'(POS_SAT)) begin
        st_next.char_position = st.char_position + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

/* rtl/idck_judge.sv */
// Verdict on the final character: error priority, date, sex, zodiac and star sign.
// Pure combinational. Depends on idck_pkg.
module idck_judge (
  input  idck_pkg::acc_state_t st,
  input  logic [7:0]           char_code,
  output idck_pkg::res_t       res
);
  import idck_pkg::*;

  err_code_t  err;
  logic       date_bad;
  logic [3:0] m;
  logic [4:0] dd;
  logic [3:0] animal;
  logic [3:0] star;

  assign m  = st.month_digits[3:0];
  assign dd = st.day_digits[4:0];

  assign date_bad = (st.month_digits == 7'd0) || (st.month_digits > 7'd12) ||
                    (st.day_digits == 7'd0) || (st.day_digits > 7'd31);

  always_comb begin
    if (st.char_position != 5'(ID_LEN - 1)) begin
      err = ERR_LENGTH;
    end else if (st.saw_non_digit) begin
      err = ERR_NON_DIGIT;
    end else if (!(is_digit(char_code) || char_code == CHAR_X_LOWER ||
                   char_code == CHAR_X_UPPER)) begin
      err = ERR_CHECK_FORM;
    end else if (char_code != check_char(st.weighted_sum_mod)) begin
      err = ERR_CHECKSUM;
    end else if (date_bad) begin
      err = ERR_DATE;
    end else begin
      err = ERR_OK;
    end
  end

  // 32-bit wrap of year - 4 for year < 4 lands back on year mod 12
  assign animal = (st.year_digits < 14'd4) ? st.year_digits[3:0]
                                           : mod12(15'(st.year_digits) + 15'd8);

  assign star = (dd < star_cut(m)) ? (m - 4'd1) : ((m == 4'd12) ? 4'd0 : m);

  always_comb begin
    res            = '0;
    res.error_code = err;
    if (err == ERR_OK) begin
      res.valid_res    = 1'b1;
      res.birth_year   = st.year_digits;
      res.birth_month  = m;
      res.birth_day    = dd;
      res.is_female    = ~st.sex_digit_odd;
      res.animal_index = animal;
      res.star_index   = star;
    end
  end

endmodule

/* rtl/id_number_checksum_validator_unit.sv */
// ID number MOD 11-2 checker, one character per request, result on final char.
// A final character is held in the input register, and its verdict is registered in
// the result register when it retires. Throughput: one request per cycle;
// a final character waits in the input register only while a stalled result is held.
// Synchronous active-high reset empties both and clears the state.
module id_number_checksum_validator_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  idck_pkg::req_t req_data,
  output logic           res_valid,
  input  logic           res_stall,
  output idck_pkg::res_t res_data
);
  import idck_pkg::*;

  logic       s1_valid;
  req_t       s1;
  logic       retire;
  acc_state_t st;
  res_t       verdict;

  assign retire    = s1_valid && (!s1.is_last || !res_valid || !res_stall);
  assign req_stall = s1_valid && !retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1 <= req_data;
    end
  end

  idck_acc u_acc (
    .clk  (clk),
    .rst  (rst),
    .fire (retire),
    .req  (s1),
    .st   (st)
  );

  idck_judge u_judge (
    .st        (st),
    .char_code (s1.char_code),
    .res       (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (retire && s1.is_last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && s1.is_last) begin
      res_data <= verdict;
    end
  end

endmodule

/* rtl/idck_checker.sv */
// Port-level checks for the ID number checker, and the bind that attaches them.
// Depends on idck_pkg and id_number_checksum_validator_unit.
module idck_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input idck_pkg::res_t res_data
);
  import idck_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.valid_res == (res_data.error_code == ERR_OK)))
    else $error("pass flag and error code disagree");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.valid_res |-> res_data.birth_year == 14'd0 &&
      res_data.birth_month == 4'd0 && res_data.birth_day == 5'd0 &&
      !res_data.is_female && res_data.animal_index == 4'd0 &&
      res_data.star_index == 4'd0)
    else $error("failed number carries date fields");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.valid_res |-> res_data.birth_month >= 4'd1 &&
      res_data.birth_month <= 4'd12 && res_data.birth_day >= 5'd1 &&
      res_data.animal_index < 4'd12 && res_data.star_index < 4'd12)
    else $error("passing number out of range");

endmodule

bind id_number_checksum_validator_unit idck_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);
